// File: rtl/i2cbe_pkg.sv
// Shared types, opcodes and command lengths for the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none

package i2cbe_pkg;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4,
    OP_ACK      = 3'd5,
    OP_NACK     = 3'd6,
    OP_WAIT_ACK = 3'd7
  } opcode_t;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] LSB_MASK = 8'h01;

  // Engine state carried from one bus period to the next.
  typedef struct packed {
    opcode_t    cmd;
    logic [4:0] phase;
    logic [3:0] bits;
    logic [7:0] shreg;
    logic       scl;
    logic       sda;
    logic       success;
    logic [7:0] rx_hold;
  } state_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ok;
    logic [7:0] rx_byte;
  } result_t;

  // Number of bus periods per command.
  function automatic logic [4:0] cmd_len(input opcode_t op);
    logic [4:0] len;
    unique case (op)
      OP_START:    len = 5'd3;
      OP_STOP:     len = 5'd4;
      OP_WRITE:    len = 5'd24;
      OP_READ:     len = 5'd16;
      OP_ACK:      len = 5'd4;
      OP_NACK:     len = 5'd4;
      OP_WAIT_ACK: len = 5'd3;
      default:     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/i2cbe_if.sv
// Request and result channel interfaces of the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none

interface i2cbe_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       sda_level;

  modport source (output valid, output opcode, output tx_byte, output sda_level,
                  input ready);
  modport sink (input valid, input opcode, input tx_byte, input sda_level,
                output ready);
endinterface

interface i2cbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic       ok;
  logic [7:0] rx_byte;

  modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                  output done_res, output ok, output rx_byte, input ready);
  modport sink (input valid, input scl_drive, input sda_drive, input busy_res,
                input done_res, input ok, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/i2cbe_step.sv
// Next-state logic: advances the engine by one bus period.
`timescale 1ns / 1ps
`default_nettype none

module i2cbe_step (
  input  var i2cbe_pkg::state_t cur,
  input  var i2cbe_pkg::opcode_t opcode,
  input  wire logic [7:0]        tx_byte,
  input  wire logic              sda_level,
  output var i2cbe_pkg::state_t  nxt,
  output logic                   done
);

  // phase mod 3 for the write command
  localparam logic [1:0] MOD3 [0:31] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
  };

  // Line levels on entry to a period.
  function automatic i2cbe_pkg::state_t enter(input i2cbe_pkg::state_t s,
                                              input i2cbe_pkg::opcode_t c,
                                              input logic [4:0] p);
    i2cbe_pkg::state_t r;
    r = s;
    unique case (c)
      i2cbe_pkg::OP_START: begin
        if (p == 5'd0) begin
          r.scl = 1'b1;
          r.sda = 1'b1;
        end else begin
          r.sda = 1'b0;
        end
      end
      i2cbe_pkg::OP_STOP: begin
        priority case (p)
          5'd0:    r.scl = 1'b0;
          5'd1:    r.sda = 1'b0;
          5'd2:    r.scl = 1'b1;
          default: r.sda = 1'b1;
        endcase
      end
      i2cbe_pkg::OP_WRITE: begin
        unique case (MOD3[p])
          2'd0: r.scl = 1'b0;
          2'd1: begin
            r.sda   = (s.shreg & i2cbe_pkg::MSB_MASK) != 8'd0;
            r.shreg = {s.shreg[6:0], 1'b0};
          end
          default: r.scl = 1'b1;
        endcase
      end
      i2cbe_pkg::OP_READ: r.scl = p[0];
      i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: begin
        priority case (p)
          5'd0:    r.scl = 1'b0;
          5'd1:    r.sda = (c == i2cbe_pkg::OP_NACK);
          5'd2:    r.scl = 1'b1;
          default: r.scl = 1'b0;
        endcase
      end
      i2cbe_pkg::OP_WAIT_ACK: begin
        priority case (p)
          5'd0:    r.scl = 1'b0;
          5'd1:    r.sda = 1'b1;
          default: r.scl = 1'b1;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  i2cbe_pkg::state_t  s;
  i2cbe_pkg::opcode_t c;
  logic [4:0]         p1;
  logic               fail;

  always_comb begin
    s    = cur;
    c    = cur.cmd;
    p1   = cur.phase + 5'd1;
    fail = 1'b0;
    done = 1'b0;
    if (cur.cmd == i2cbe_pkg::OP_NONE) begin
      if (opcode != i2cbe_pkg::OP_NONE) begin
        s.cmd   = opcode;
        s.phase = 5'd0;
        s.bits  = 4'd0;
        if (opcode == i2cbe_pkg::OP_WRITE) s.shreg = tx_byte;
        if (opcode == i2cbe_pkg::OP_READ) begin
          s.shreg = 8'd0;
          s.sda   = 1'b1;
        end
        s = enter(s, opcode, 5'd0);
      end
    end else begin
      unique case (c)
        i2cbe_pkg::OP_START: begin
          if (cur.phase == 5'd0 && !sda_level) fail = 1'b1;
          if (cur.phase == 5'd1 && sda_level) fail = 1'b1;
        end
        i2cbe_pkg::OP_WRITE: begin
          if (MOD3[cur.phase] == 2'd2) s.bits = cur.bits + 4'd1;
        end
        i2cbe_pkg::OP_READ: begin
          if (cur.phase[0]) begin
            s.shreg = {cur.shreg[6:0], sda_level};
            s.bits  = cur.bits + 4'd1;
          end
        end
        i2cbe_pkg::OP_WAIT_ACK: begin
          if (cur.phase == 5'd2) s.success = !sda_level;
        end
        default: ;
      endcase

      if (fail) begin
        s.success = 1'b0;
        done      = 1'b1;
      end else if (p1 >= i2cbe_pkg::cmd_len(c)) begin
        done = 1'b1;
        if (c != i2cbe_pkg::OP_WAIT_ACK) s.success = 1'b1;
        if (c == i2cbe_pkg::OP_WRITE || c == i2cbe_pkg::OP_READ ||
            c == i2cbe_pkg::OP_WAIT_ACK) s.scl = 1'b0;
        if (c == i2cbe_pkg::OP_READ) s.rx_hold = s.shreg;
      end else begin
        s.phase = p1;
        s = enter(s, c, p1);
      end
      if (done) begin
        s.cmd   = i2cbe_pkg::OP_NONE;
        s.phase = 5'd0;
      end
    end
    nxt = s;
  end

endmodule

`default_nettype wire

// File: rtl/i2cbe_out_buf.sv
// Result register with a one-entry skid stage.
`timescale 1ns / 1ps
`default_nettype none

module i2cbe_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  var i2cbe_pkg::result_t push_data,
  output logic                  can_push,
  i2cbe_res_if.source           res
);

  logic                out_valid;
  i2cbe_pkg::result_t  out_data;
  logic                skid_valid;
  i2cbe_pkg::result_t  skid_data;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.ready || !out_valid) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign res.valid     = out_valid;
  assign res.scl_drive = out_data.scl_drive;
  assign res.sda_drive = out_data.sda_drive;
  assign res.busy_res  = out_data.busy_res;
  assign res.done_res  = out_data.done_res;
  assign res.ok        = out_data.ok;
  assign res.rx_byte   = out_data.rx_byte;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("request accepted while the skid stage is full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && res.ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to the output register");

endmodule

`default_nettype wire

// File: rtl/i2c_master_bit_engine_unit.sv
// Top level of the I2C master bit engine: state registers, step logic, result buffer.
`timescale 1ns / 1ps
`default_nettype none

// I2C master bit engine.
// cmd channel: one request per bus delay period. It carries opcode (taken only
// while idle), tx_byte (latched by a write command) and sda_level, the SDA
// level sampled over the period that just ended.
// res channel: exactly one result per request: the SCL/SDA drive levels for
// the next period (1 released, 0 pulled low), busy, a done pulse, ok and the
// byte from the last completed read.
// A result is registered in the output register, or the skid stage if res is
// held off, as its request is accepted. One request per cycle while cmd.ready
// is high; a single pass of step logic lies between state and result registers.
// START takes 3 periods, STOP 4, WRITE 24, READ 16, ACK/NACK 4, WAIT_ACK 3.
// Reset (synchronous, active high): idle, both lines released, ok 1,
// read byte 0, output and skid stages empty.
// Stall: while res is held off, one more result goes to the skid stage; then
// cmd.ready drops until the output register drains.
module i2c_master_bit_engine_unit (
  input wire logic    clk,
  input wire logic    rst,
  i2cbe_req_if.sink   cmd,
  i2cbe_res_if.source res
);

  i2cbe_pkg::state_t  state;
  i2cbe_pkg::state_t  state_next;
  i2cbe_pkg::result_t result;
  logic               step_done;
  logic               can_push;
  logic               accept;

  assign cmd.ready = can_push;
  assign accept    = cmd.valid && can_push;

  i2cbe_step u_step (
    .cur       (state),
    .opcode    (i2cbe_pkg::opcode_t'(cmd.opcode)),
    .tx_byte   (cmd.tx_byte),
    .sda_level (cmd.sda_level),
    .nxt       (state_next),
    .done      (step_done)
  );

  // engine state advances one bus period per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.cmd     <= i2cbe_pkg::OP_NONE;
      state.phase   <= 5'd0;
      state.bits    <= 4'd0;
      state.shreg   <= 8'd0;
      state.scl     <= 1'b1;
      state.sda     <= 1'b1;
      state.success <= 1'b1;
      state.rx_hold <= 8'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_comb begin
    result.scl_drive = state_next.scl;
    result.sda_drive = state_next.sda;
    result.busy_res  = state_next.cmd != i2cbe_pkg::OP_NONE;
    result.done_res  = step_done;
    result.ok        = state_next.success;
    result.rx_byte   = state_next.rx_hold;
  end

  i2cbe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .res       (res)
  );

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (rst)
    (state.cmd == i2cbe_pkg::OP_NONE) |-> (state.phase == 5'd0))
    else $error("phase count nonzero while idle");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    (state.cmd != i2cbe_pkg::OP_NONE) |-> (state.phase < i2cbe_pkg::cmd_len(state.cmd)))
    else $error("phase count beyond command length");

  a_done_ends_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && step_done) |=> (state.cmd == i2cbe_pkg::OP_NONE))
    else $error("command still active after done");

  a_busy_holds_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && state.cmd != i2cbe_pkg::OP_NONE && !step_done) |=> $stable(state.cmd))
    else $error("active command changed before done");

  a_idle_no_done: assert property (@(posedge clk) disable iff (rst)
    (state.cmd == i2cbe_pkg::OP_NONE) |-> !step_done)
    else $error("done raised while idle");

endmodule

`default_nettype wire
